### rtl/rat_pkg.sv
// Shared constants, codes and types for the relay autotuner.
// No dependencies; every other file of the block imports this package.
package rat_pkg;

    // field widths
    localparam int TEMP_W     = 15;
    localparam int HYST_W     = 12;
    localparam int PER_W      = 4;
    localparam int SPAN_W     = 7;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 36;
    localparam int GAIN_W     = 32;

    // fixed point formats
    localparam int TEMP_FRAC_BITS = 4;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int PI_FRAC_BITS   = 28;
    localparam int GAIN_SHIFT     = TEMP_FRAC_BITS + GAIN_FRAC_BITS + PI_FRAC_BITS;

    // serial arithmetic widths
    localparam int WIDE_W     = 128;
    localparam int MUL_A_W    = 64;
    localparam int MUL_B_W    = 36;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W + 1);
    localparam int DIV_CNT_W  = $clog2(GAIN_W + 1);

    // 5 * pi in Q28
    localparam logic [31:0] PI5_Q28  = 32'd4216574285;
    localparam logic [3:0]  KP_SCALE = 4'd12;
    localparam logic [25:0] KI_SCALE = 26'd24000;
    localparam logic [14:0] KD_DEN_SCALE = 15'd2000;
    localparam logic [8:0]  KD_NUM_SCALE = 9'd3;

    // run start values of the extremes
    localparam logic signed [TEMP_W-1:0] HIGH_INIT = -15'sd16000;
    localparam logic signed [TEMP_W-1:0] LOW_INIT  = 15'sd16000;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 2'd3;

    // item opcodes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // operands handed to the gain sequencer
    typedef struct packed {
        logic [TEMP_W-1:0] diff;
        logic [SUM_W-1:0]  sum;
        logic [PER_W-1:0]  count;
        logic [SPAN_W-1:0] span;
    } gain_opnd_t;

    // status of a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

### rtl/rat_if.sv
// Handshake interfaces for sample items and result items.
// Depends on rat_pkg for field widths.
interface rat_sample_if
    import rat_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [TEMP_W-1:0] temperature;
    logic [TIME_W-1:0]        time_ms;

    modport source (output valid, op, temperature, time_ms, input ready);
    modport sink   (input valid, op, temperature, time_ms, output ready);
endinterface

interface rat_result_if
    import rat_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              relay_on;
    logic [PER_W-1:0]  periods_seen;
    logic              done_res;
    logic              bad_measurement;
    logic [GAIN_W-1:0] proportional_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] derivative_gain;

    modport source (output valid, relay_on, periods_seen, done_res, bad_measurement,
                    proportional_gain, integral_gain, derivative_gain, input ready);
    modport sink   (input valid, relay_on, periods_seen, done_res, bad_measurement,
                    proportional_gain, integral_gain, derivative_gain, output ready);
endinterface

### rtl/rat_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rat_pkg.
module rat_serial_mul
    import rat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output unit_stat_t         stat,
    output logic [WIDE_W-1:0]  product
);

    logic [WIDE_W-1:0]    mcand_reg;
    logic [MUL_B_W-1:0]   mplier_reg;
    logic [WIDE_W-1:0]    acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: multiplier shifts out LSB first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= WIDE_W'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

### rtl/rat_serial_div.sv
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on rat_pkg.
module rat_serial_div
    import rat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] num,
    input  logic [WIDE_W-1:0] den,
    output unit_stat_t        stat,
    output logic [GAIN_W-1:0] quot
);

    logic [WIDE_W-1:0]    rem_reg;
    logic [WIDE_W-1:0]    dsh_reg;
    logic [GAIN_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 sat;
    logic                 ge;

    // quotient would not fit in 32 bits
    assign sat = (num >= (den << GAIN_W));
    assign ge  = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (sat)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= DIV_CNT_W'(GAIN_W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= den << (GAIN_W - 1);
            quot_reg <= sat ? '1 : '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[GAIN_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

### rtl/rat_gain_seq.sv
// Sequencer for the Ziegler-Nichols gains: four serial products, three divisions.
// Depends on rat_pkg, rat_serial_mul and rat_serial_div.
module rat_gain_seq
    import rat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gain_opnd_t        opnd,
    output unit_stat_t        stat,
    output logic [GAIN_W-1:0] kp,
    output logic [GAIN_W-1:0] ki,
    output logic [GAIN_W-1:0] kd
);

    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_DEN0 = 3'd1;
    localparam logic [2:0] SQ_DEN1 = 3'd2;
    localparam logic [2:0] SQ_DEN2 = 3'd3;
    localparam logic [2:0] SQ_NUM2 = 3'd4;
    localparam logic [2:0] SQ_KP   = 3'd5;
    localparam logic [2:0] SQ_KI   = 3'd6;
    localparam logic [2:0] SQ_KD   = 3'd7;

    logic [2:0]         state_reg;
    logic               launch_reg;
    logic               done_reg;
    gain_opnd_t         opnd_reg;
    logic [10:0]        spn_reg;
    logic [MUL_A_W-1:0] den0_reg;
    logic [WIDE_W-1:0]  den1_reg;
    logic [MUL_A_W-1:0] den2_reg;
    logic [MUL_A_W-1:0] num2m_reg;
    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_reg;
    logic [GAIN_W-1:0]  kd_reg;

    logic               is_mul;
    logic               mul_start;
    logic               div_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [WIDE_W-1:0]  div_num;
    logic [WIDE_W-1:0]  div_den;
    unit_stat_t         mul_stat;
    unit_stat_t         div_stat;
    logic [WIDE_W-1:0]  product;
    logic [GAIN_W-1:0]  quot;
    logic               step_done;

    // operand selection per step
    always_comb
    begin
        is_mul  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        unique case (state_reg)
            SQ_DEN0:
            begin
                is_mul = 1'b1;
                mul_a  = MUL_A_W'(PI5_Q28);
                mul_b  = MUL_B_W'(opnd_reg.diff);
            end
            SQ_DEN1:
            begin
                is_mul = 1'b1;
                mul_a  = den0_reg;
                mul_b  = opnd_reg.sum;
            end
            SQ_DEN2:
            begin
                is_mul = 1'b1;
                mul_a  = den0_reg;
                mul_b  = MUL_B_W'(15'(opnd_reg.count) * KD_DEN_SCALE);
            end
            SQ_NUM2:
            begin
                is_mul = 1'b1;
                mul_a  = MUL_A_W'(opnd_reg.sum);
                mul_b  = MUL_B_W'(9'(opnd_reg.span) * KD_NUM_SCALE);
            end
            SQ_KP:
            begin
                div_num = WIDE_W'(11'(opnd_reg.span) * 11'(KP_SCALE)) << GAIN_SHIFT;
                div_den = WIDE_W'(den0_reg);
            end
            SQ_KI:
            begin
                div_num = WIDE_W'(26'(spn_reg) * KI_SCALE) << GAIN_SHIFT;
                div_den = den1_reg;
            end
            SQ_KD:
            begin
                div_num = WIDE_W'(num2m_reg) << GAIN_SHIFT;
                div_den = WIDE_W'(den2_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = launch_reg && is_mul;
    assign div_start = launch_reg && !is_mul && (state_reg != SQ_IDLE);
    assign step_done = !launch_reg && (is_mul ? mul_stat.done : div_stat.done);

    rat_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (product)
    );

    rat_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (quot)
    );

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SQ_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            launch_reg <= 1'b0;
            if (state_reg == SQ_IDLE)
            begin
                if (start)
                begin
                    state_reg  <= SQ_DEN0;
                    launch_reg <= 1'b1;
                end
            end
            else if (step_done)
            begin
                if (state_reg == SQ_KD)
                begin
                    state_reg <= SQ_IDLE;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    state_reg  <= state_reg + 1'b1;
                    launch_reg <= 1'b1;
                end
            end
        end
    end

    // captured operands and intermediate results
    always_ff @(posedge clk)
    begin
        if (state_reg == SQ_IDLE && start)
        begin
            opnd_reg <= opnd;
            spn_reg  <= 11'(opnd.span) * 11'(opnd.count);
        end
        if (step_done)
        begin
            unique case (state_reg)
                SQ_DEN0: den0_reg  <= product[MUL_A_W-1:0];
                SQ_DEN1: den1_reg  <= product;
                SQ_DEN2: den2_reg  <= product[MUL_A_W-1:0];
                SQ_NUM2: num2m_reg <= product[MUL_A_W-1:0];
                SQ_KP:   kp_reg    <= quot;
                SQ_KI:   ki_reg    <= quot;
                SQ_KD:   kd_reg    <= quot;
                default: ;
            endcase
        end
    end

    assign stat.busy = (state_reg != SQ_IDLE);
    assign stat.done = done_reg;
    assign kp = kp_reg;
    assign ki = ki_reg;
    assign kd = kd_reg;

endmodule

### rtl/relay_autotune_pid_gains_core.sv
// Top level of the relay-feedback autotuner with classic PID gain calculation.
// Depends on rat_pkg, rat_if and rat_gain_seq.
//
// A start item (op 0) arms a run; each sample item (op 1) updates the extremes,
// the relay and the period measurement, and every item returns one result item
// showing the state after it. Start items, ignored samples and ordinary samples
// go from the accepting state to the emit state, which loads the result register
// once the last result is taken; no new item is accepted until then. The sample
// that completes the run first passes the calculation state, where the gain
// sequencer runs four shift-and-add products of 36 steps each and three restoring
// divisions of 32 steps each, one bit per cycle. A bad measurement skips the
// sequencer. A result may wait in its register while the next item is accepted.
module relay_autotune_pid_gains_core
    import rat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rat_sample_if.sink            sample_ch,
    rat_result_if.source          result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // configuration
    logic signed [TEMP_W-1:0] target_reg;
    logic [HYST_W-1:0]        hyst_reg;
    logic [PER_W-1:0]         req_reg;
    logic [SPAN_W-1:0]        span_reg;

    // run state
    logic [1:0]               state_reg;
    logic                     relay_reg,    relay_next;
    logic                     running_reg,  running_next;
    logic                     finished_reg, finished_next;
    logic [PER_W-1:0]         count_reg,    count_next;
    logic [SUM_W-1:0]         sum_reg,      sum_next;
    logic [TIME_W-1:0]        last_on_reg,  last_on_next;
    logic                     on_valid_reg, on_valid_next;
    logic signed [TEMP_W-1:0] high_reg,     high_next;
    logic signed [TEMP_W-1:0] low_reg,      low_next;
    logic                     error_reg,    error_next;
    logic [GAIN_W-1:0]        kp_reg, ki_reg, kd_reg;
    logic                     out_valid_reg;

    logic                     accept;
    logic                     finish;
    logic                     bad;
    logic                     seq_start;
    logic signed [16:0]       t_x;
    logic signed [16:0]       on_thr;
    logic signed [16:0]       off_thr;
    logic signed [15:0]       diff;
    logic [TIME_W-1:0]        interval;
    gain_opnd_t               opnd;
    unit_stat_t               seq_stat;
    logic [GAIN_W-1:0]        seq_kp, seq_ki, seq_kd;

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign accept = sample_ch.valid && sample_ch.ready;

    // thresholds around the setpoint
    assign t_x     = 17'(sample_ch.temperature);
    assign on_thr  = 17'(target_reg) - $signed({5'b0, hyst_reg});
    assign off_thr = 17'(target_reg) + $signed({5'b0, hyst_reg});
    assign interval = sample_ch.time_ms - last_on_reg;

    // effect of one item on the run state
    always_comb
    begin
        relay_next    = relay_reg;
        running_next  = running_reg;
        finished_next = finished_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_on_next  = last_on_reg;
        on_valid_next = on_valid_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        error_next    = error_reg;
        finish        = 1'b0;
        if (sample_ch.op == OP_START)
        begin
            relay_next    = 1'b0;
            running_next  = 1'b1;
            finished_next = 1'b0;
            count_next    = '0;
            sum_next      = '0;
            last_on_next  = '0;
            on_valid_next = 1'b0;
            high_next     = HIGH_INIT;
            low_next      = LOW_INIT;
            error_next    = 1'b0;
        end
        else if (running_reg)
        begin
            if (sample_ch.temperature > high_reg)
            begin
                high_next = sample_ch.temperature;
            end
            if (sample_ch.temperature < low_reg)
            begin
                low_next = sample_ch.temperature;
            end
            if (!relay_reg && t_x < on_thr)
            begin
                relay_next = 1'b1;
                if (on_valid_reg)
                begin
                    sum_next   = sum_reg + SUM_W'(interval);
                    count_next = count_reg + 1'b1;
                end
                last_on_next  = sample_ch.time_ms;
                on_valid_next = 1'b1;
            end
            else if (relay_reg && t_x > off_thr)
            begin
                relay_next = 1'b0;
            end
            if (count_next >= req_reg)
            begin
                relay_next    = 1'b0;
                running_next  = 1'b0;
                finished_next = 1'b1;
                finish        = 1'b1;
            end
        end
    end

    // measurement check
    assign diff = 16'(high_next) - 16'(low_next);
    assign bad  = (diff <= 16'sd0) || (sum_next == '0) || (count_next == '0);
    assign seq_start = accept && finish && !bad;

    assign opnd.diff  = diff[TEMP_W-1:0];
    assign opnd.sum   = sum_next;
    assign opnd.count = count_next;
    assign opnd.span  = span_reg;

    rat_gain_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .opnd  (opnd),
        .stat  (seq_stat),
        .kp    (seq_kp),
        .ki    (seq_ki),
        .kd    (seq_kd)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            hyst_reg   <= HYST_W'(8);
            req_reg    <= PER_W'(5);
            span_reg   <= SPAN_W'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET:  target_reg <= cfg_data[TEMP_W-1:0];
                REG_HYST:    hyst_reg   <= cfg_data[HYST_W-1:0];
                REG_PERIODS: req_reg    <= cfg_data[PER_W-1:0];
                REG_SPAN:    span_reg   <= cfg_data[SPAN_W-1:0];
                default:     ;
            endcase
        end
    end

    // run state and item sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            relay_reg     <= 1'b0;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            last_on_reg   <= '0;
            on_valid_reg  <= 1'b0;
            high_reg      <= HIGH_INIT;
            low_reg       <= LOW_INIT;
            error_reg     <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result valid: set on load, cleared when taken
            if (state_reg == ST_EMIT && (!out_valid_reg || result_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        relay_reg    <= relay_next;
                        running_reg  <= running_next;
                        finished_reg <= finished_next;
                        count_reg    <= count_next;
                        sum_reg      <= sum_next;
                        last_on_reg  <= last_on_next;
                        on_valid_reg <= on_valid_next;
                        high_reg     <= high_next;
                        low_reg      <= low_next;
                        error_reg    <= (finish && bad) ? 1'b1 : error_next;
                        if (sample_ch.op == OP_START)
                        begin
                            kp_reg <= '0;
                            ki_reg <= '0;
                            kd_reg <= '0;
                        end
                        else if (finish && bad)
                        begin
                            kp_reg <= '1;
                            ki_reg <= '1;
                            kd_reg <= '1;
                        end
                        state_reg <= (finish && !bad) ? ST_CALC : ST_EMIT;
                    end
                end
                ST_CALC:
                begin
                    if (seq_stat.done)
                    begin
                        kp_reg    <= seq_kp;
                        ki_reg    <= seq_ki;
                        kd_reg    <= seq_kd;
                        error_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || result_ch.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && (!out_valid_reg || result_ch.ready))
        begin
            result_ch.relay_on          <= relay_reg;
            result_ch.periods_seen      <= count_reg;
            result_ch.done_res          <= finished_reg;
            result_ch.bad_measurement   <= error_reg;
            result_ch.proportional_gain <= kp_reg;
            result_ch.integral_gain     <= ki_reg;
            result_ch.derivative_gain   <= kd_reg;
        end
    end

    assign result_ch.valid = out_valid_reg;

endmodule

### rtl/rat_checker.sv
// Port-level checks for the autotuner, bound to the top level.
// Depends on rat_pkg; sees the top level's ports only.
module rat_checker
    import rat_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic              relay_on,
    input logic              done_res,
    input logic              bad_measurement,
    input logic [GAIN_W-1:0] kp,
    input logic [GAIN_W-1:0] ki,
    input logic [GAIN_W-1:0] kd
);

    // a stalled result stays valid and keeps its relay, done flag and gains
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable({relay_on, done_res, kp, ki, kd}))
        else $error("stalled result changed");

    // a finished run leaves the relay off
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !relay_on)
        else $error("relay on after run finished");

    // a bad measurement saturates all gains
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_measurement |-> done_res && (&kp) && (&ki) && (&kd))
        else $error("bad measurement without saturated gains");

    // gains stay clear until a run finishes
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !done_res |-> !bad_measurement && kp == '0 && ki == '0 && kd == '0)
        else $error("gains set before run finished");

endmodule

bind relay_autotune_pid_gains_core rat_checker u_rat_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result_ch.valid),
    .res_ready       (result_ch.ready),
    .relay_on        (result_ch.relay_on),
    .done_res        (result_ch.done_res),
    .bad_measurement (result_ch.bad_measurement),
    .kp              (result_ch.proportional_gain),
    .ki              (result_ch.integral_gain),
    .kd              (result_ch.derivative_gain)
);

### tb/tb_relay_autotune_pid_gains_core.sv
// Self-checking testbench for relay_autotune_pid_gains_core.
// Depends on rat_pkg and the rat_sample_if / rat_result_if interfaces.
module tb_relay_autotune_pid_gains_core;
    import rat_pkg::*;

    // one result item as the block returns it
    typedef struct packed {
        logic              relay_on;
        logic [PER_W-1:0]  periods_seen;
        logic              done_res;
        logic              bad_measurement;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } tune_res_t;

    // autotuner predictor and store of expected result items
    class tune_scoreboard;
        int setpoint;
        int band;
        int periods_req;
        int span;
        bit relay;
        bit armed;
        bit done;
        bit bad;
        logic [PER_W-1:0] n_periods;
        logic [SUM_W-1:0] sum_ms;
        logic [TIME_W-1:0] last_on;
        bit last_on_ok;
        int t_high;
        int t_low;
        logic [GAIN_W-1:0] gains [3];
        tune_res_t expected_q [$];
        int mismatches;

        function void clear_run();
            relay = 0;
            done = 0;
            n_periods = '0;
            sum_ms = '0;
            last_on = '0;
            last_on_ok = 0;
            t_high = -16000;
            t_low = 16000;
            foreach (gains[i]) gains[i] = '0;
            bad = 0;
        endfunction

        function void reset_state();
            setpoint = 0;
            band = 8;
            periods_req = 5;
            span = 100;
            clear_run();
            armed = 0;
            mismatches = 0;
        endfunction

        function logic [GAIN_W-1:0] div_sat(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            if (den == 0)
                return '1;
            q = num / den;
            return (q >= 128'h1_0000_0000) ? '1 : q[31:0];
        endfunction

        function void work_out_gains();
            int diff;
            logic [127:0] base;
            logic [127:0] sp;
            logic [127:0] n;
            logic [127:0] s;
            diff = t_high - t_low;
            if (diff <= 0 || sum_ms == 0 || n_periods == 0) begin
                foreach (gains[i]) gains[i] = '1;
                bad = 1;
                return;
            end
            sp = span;
            n = n_periods;
            s = sum_ms;
            base = 128'd843314857 * diff;
            gains[0] = div_sat((12 * sp) << GAIN_SHIFT, 5 * base);
            gains[1] = div_sat((24000 * sp * n) << GAIN_SHIFT, 5 * base * s);
            gains[2] = div_sat((3 * sp * s) << GAIN_SHIFT, 10000 * base * n);
            bad = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TARGET:  setpoint = int'($signed(val[14:0]));
                REG_HYST:    band = int'(val[11:0]);
                REG_PERIODS: periods_req = int'(val[3:0]);
                REG_SPAN:    span = int'(val[6:0]);
                default: ;
            endcase
        endfunction

        // note an accepted input item and queue its expected result
        function void note_input(logic op, logic signed [TEMP_W-1:0] temp,
                                 logic [TIME_W-1:0] now);
            int t;
            tune_res_t r;
            t = int'(temp);
            if (op == OP_START) begin
                clear_run();
                armed = 1;
            end else if (armed) begin
                if (t > t_high) t_high = t;
                if (t < t_low) t_low = t;
                if (!relay && t < setpoint - band) begin
                    relay = 1;
                    if (last_on_ok) begin
                        sum_ms = sum_ms + SUM_W'(TIME_W'(now - last_on));
                        n_periods = n_periods + 1'b1;
                    end
                    last_on = now;
                    last_on_ok = 1;
                end else if (relay && t > setpoint + band) begin
                    relay = 0;
                end
                if (int'(n_periods) >= periods_req) begin
                    relay = 0;
                    armed = 0;
                    done = 1;
                    work_out_gains();
                end
            end
            r.relay_on = relay;
            r.periods_seen = n_periods;
            r.done_res = done;
            r.bad_measurement = bad;
            r.kp = gains[0];
            r.ki = gains[1];
            r.kd = gains[2];
            expected_q.push_back(r);
        endfunction

        // compare one result item with the oldest expectation
        function void check_result(tune_res_t got);
            tune_res_t exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.relay_on !== exp_r.relay_on || got.periods_seen !== exp_r.periods_seen
                || got.done_res !== exp_r.done_res
                || got.bad_measurement !== exp_r.bad_measurement
                || got.kp !== exp_r.kp || got.ki !== exp_r.ki || got.kd !== exp_r.kd) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("result mismatch: exp relay %0b n %0d done %0b bad %0b ",
                           exp_r.relay_on, exp_r.periods_seen, exp_r.done_res,
                           exp_r.bad_measurement);
                    $write("kp %h ki %h kd %h, ", exp_r.kp, exp_r.ki, exp_r.kd);
                    $write("got relay %0b n %0d done %0b bad %0b ",
                           got.relay_on, got.periods_seen, got.done_res,
                           got.bad_measurement);
                    $display("kp %h ki %h kd %h", got.kp, got.ki, got.kd);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rat_sample_if sample_ch ();
    rat_result_if result_ch ();

    relay_autotune_pid_gains_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch.sink),
        .result_ch (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tune_scoreboard sb;
    bit calm;          // no idling on either side
    bit stall_go;      // asks the receiver for a long hold-off
    logic [TIME_W-1:0] clock_ms;

    initial clk = 0;
    always #5 clk = ~clk;

    // hard limit on the run
    initial
    begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

    // note accepted input items and check accepted result items
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            sb.note_input(sample_ch.op, sample_ch.temperature, sample_ch.time_ms);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result({result_ch.relay_on, result_ch.periods_seen, result_ch.done_res,
                             result_ch.bad_measurement, result_ch.proportional_gain,
                             result_ch.integral_gain, result_ch.derivative_gain});
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_go)
            begin
                stall_go = 0;
                result_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // offer one item and wait for it to be taken; may idle afterwards
    task automatic send_item(logic op, logic signed [TEMP_W-1:0] temp,
                             logic [TIME_W-1:0] now);
        sample_ch.valid <= 1'b1;
        sample_ch.op <= op;
        sample_ch.temperature <= temp;
        sample_ch.time_ms <= now;
        do @(posedge clk); while (!sample_ch.ready);
        if (!calm && $urandom_range(99) < 32)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // register write; the caller lowers the enable
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // pause the sender until nothing is expected, then let the block settle
    task automatic drain();
        sample_ch.valid <= 1'b0;
        cfg_we <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_config(int tgt, int hy, int per, int sp);
        drain();
        write_reg(REG_TARGET, CFG_DATA_W'(tgt));
        write_reg(REG_HYST, CFG_DATA_W'(hy));
        write_reg(REG_PERIODS, CFG_DATA_W'(per));
        write_reg(REG_SPAN, CFG_DATA_W'(sp));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] tick();
        clock_ms = clock_ms + $urandom_range(1, 3000);
        return clock_ms;
    endfunction

    // one run: start, then samples mostly swinging across the band, some random or at the setpoint
    task automatic tune_run(int samples);
        int low_t;
        int high_t;
        send_item(OP_START, TEMP_W'($urandom), $urandom);
        for (int i = 0; i < samples; i++)
        begin
            low_t = sb.setpoint - sb.band - $urandom_range(1, 300);
            high_t = sb.setpoint + sb.band + $urandom_range(1, 300);
            case ($urandom_range(9))
                0: send_item(OP_SAMPLE, TEMP_W'($urandom), tick());
                1: send_item(OP_SAMPLE, TEMP_W'(sb.setpoint), tick());
                default: send_item(OP_SAMPLE, TEMP_W'((i % 2) ? high_t : low_t), tick());
            endcase
        end
    endtask

    int sent;
    int n_samp;

    initial
    begin
        sb = new();
        sb.reset_state();
        calm = 0;
        stall_go = 0;
        clock_ms = $urandom;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.op = OP_START;
        sample_ch.temperature = '0;
        sample_ch.time_ms = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sample before any start is ignored, reset settings
        send_item(OP_SAMPLE, -15'sd100, 32'd0);
        tune_run(12);
        // periods required zero: first sample ends the run as bad
        set_config(0, 8, 0, 100);
        send_item(OP_START, 15'sd0, 32'd0);
        send_item(OP_SAMPLE, 15'sd16000, 32'hFFFF_FFFF);
        // identical timestamps: zero period sum
        set_config(-16000, 0, 2, 1);
        send_item(OP_START, 15'sd0, 32'd0);
        send_item(OP_SAMPLE, -15'sd16384, 32'd77);
        send_item(OP_SAMPLE, 15'sd16383, 32'd77);
        send_item(OP_SAMPLE, -15'sd16384, 32'd77);
        send_item(OP_SAMPLE, 15'sd16383, 32'd77);
        send_item(OP_SAMPLE, -15'sd16384, 32'd77);
        // timestamp wrap, span zero, extremes of the registers
        set_config(16000, 4095, 15, 0);
        send_item(OP_START, 15'sd0, 32'd0);
        send_item(OP_SAMPLE, -15'sd16000, 32'hFFFF_FFF0);
        send_item(OP_START, 15'sd0, 32'd0);   // restart mid-run
        send_item(OP_SAMPLE, -15'sd16000, 32'hFFFF_FFF0);
        send_item(OP_SAMPLE, 15'sd16000, 32'h0000_0010);
        set_config(0, 1, 1, 127);
        tune_run(4);

        // random phases with differing settings
        sent = 40;
        for (int ph = 0; sent < 1650; ph++)
        begin
            case (ph % 4)
                0: set_config($urandom_range(0, 32000) - 16000, $urandom_range(0, 4095),
                              $urandom_range(0, 15), $urandom_range(0, 127));
                1: set_config($urandom_range(0, 2000) - 1000, $urandom_range(0, 64),
                              $urandom_range(1, 6), $urandom_range(1, 100));
                2: set_config(16000, 0, 15, 100);
                default: set_config(-16000, $urandom_range(0, 20), 1, 1);
            endcase
            calm = (ph == 5);
            if (ph == 3) stall_go = 1;
            for (int k = 0; k < 5; k++)
            begin
                n_samp = $urandom_range(2, 34);
                tune_run(n_samp);
                sent += n_samp + 1;
                if ($urandom_range(3) == 0)
                begin
                    send_item(OP_SAMPLE, TEMP_W'($urandom), $urandom);
                    sent += 1;
                end
            end
            calm = 0;
        end

        drain();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
